@@ sv/lifo_stack_engine_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LIFO_STACK_ENGINE_DEFINES_SVH
`define LIFO_STACK_ENGINE_DEFINES_SVH

// same-cycle implication
`define LSE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lse_pkg.sv @@
`default_nettype none

package lse_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int SLOT_W = 6;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_DUMP = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] push_value;
  } lse_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot_index;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;
  } lse_res_t;

  typedef struct packed {
    logic accept;
    logic step;
  } lse_ctl_t;

  typedef struct packed {
    logic last;
  } lse_sts_t;

endpackage

`default_nettype wire

@@ sv/lifo_stack_engine.sv @@
// Bounded LIFO of signed 32-bit words. A command is taken when start is high
// and busy is low; busy then stays high until the last result of that command
// has been shown. Every result appears on result for one cycle with
// result_valid high and must be captured then, as it cannot be held off.
// Push, pop and peek give one result in the cycle after the command is taken;
// busy stays high while that result is shown. A dump of n entries gives n
// results in consecutive cycles, top to bottom, each read through the single
// read port of the stack RAM. Errors (overflow, empty) give one result.
// The user must write capacity through cfg_valid/cfg_data only while the engine
// is idle; the block does not enforce this. cfg_ready is always high.
`default_nettype none

module lifo_stack_engine
  import lse_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire lse_req_t         request,
  output logic                  result_valid,
  output lse_res_t              result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  lse_ctl_t ctl;
  lse_sts_t sts;

  assign cfg_ready = 1'b1;

  lse_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .sts          (sts),
    .busy         (busy),
    .result_valid (result_valid),
    .ctl          (ctl)
  );

  lse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .sts      (sts),
    .result   (result)
  );

endmodule

`default_nettype wire

@@ sv/lse_ram.sv @@
`default_nettype none

module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/lse_ctrl.sv @@
`default_nettype none

module lse_ctrl
  import lse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire lse_sts_t sts,
  output logic          busy,
  output logic          result_valid,
  output lse_ctl_t      ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_OUT  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next   = state;
    ctl.accept   = 1'b0;
    ctl.step     = 1'b0;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        result_valid = 1'b1;
        if (sts.last) begin
          state_next = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/lse_dp.sv @@
`default_nettype none

module lse_dp
  import lse_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lse_ctl_t         ctl,
  input  wire lse_req_t         request,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  output lse_sts_t              sts,
  output lse_res_t              result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [1:0]        op;
  logic [1:0]        status;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] word_next;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     slot_next;
  logic [CNT_W-1:0]  rep_cnt;
  logic [CNT_W-1:0]  rep_cnt_next;
  logic              use_ram;
  logic              use_ram_next;

  logic [CNT_W-1:0]  eff_limit;
  logic              full;
  logic              empty;
  logic              push_ok;
  logic              pop_ok;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign eff_limit = (capacity > DEPTH_C) ? DEPTH_C : capacity;
  assign full      = (count >= eff_limit);
  assign empty     = (count == '0);
  assign push_ok   = ctl.accept && (request.command == CMD_PUSH) && !full;
  assign pop_ok    = ctl.accept && (request.command == CMD_POP) && !empty;
  assign raddr     = ctl.step ? (slot - AW'(1)) : AW'(count - CNT_W'(1));

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    status_next  = ST_OK;
    word_next    = '0;
    slot_next    = AW'(count - CNT_W'(1));
    rep_cnt_next = count;
    use_ram_next = 1'b1;
    if (request.command == CMD_PUSH) begin
      use_ram_next = 1'b0;
      if (full) begin
        status_next = ST_OVERFLOW;
        slot_next   = '0;
      end else begin
        word_next    = request.push_value;
        slot_next    = AW'(count);
        rep_cnt_next = count + CNT_W'(1);
      end
    end else if (empty) begin
      status_next  = ST_EMPTY;
      slot_next    = '0;
      rep_cnt_next = '0;
      use_ram_next = 1'b0;
    end else if (request.command == CMD_POP) begin
      rep_cnt_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      count <= count_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op      <= request.command;
      status  <= status_next;
      word    <= word_next;
      slot    <= slot_next;
      rep_cnt <= rep_cnt_next;
      use_ram <= use_ram_next;
    end else if (ctl.step) begin
      slot <= slot - AW'(1);
    end
  end

  lse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (AW'(count)),
    .wdata (request.push_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.last = !((op == CMD_DUMP) && (status == ST_OK)) || (slot == '0);

  assign result.status      = status;
  assign result.value       = use_ram ? rdata : word;
  assign result.slot_index  = SLOT_W'(slot);
  assign result.entry_count = rep_cnt;
  assign result.last        = sts.last;

endmodule

`default_nettype wire

@@ sv/lse_checker.sv @@
`default_nettype none
`include "lifo_stack_engine_defines.svh"

module lse_checker
  import lse_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     result_valid,
  input wire lse_res_t result
);

  `LSE_ASSERT_NOW(a_strobe_busy, result_valid, busy, "result shown while idle")
  `LSE_ASSERT_NEXT(a_accept_result, start && !busy, result_valid, "no result after accept")
  `LSE_ASSERT_NEXT(a_last_frees, result_valid && result.last, !busy, "busy after last word")
  `LSE_ASSERT_NEXT(a_run_cont, result_valid && !result.last, result_valid, "dump run broken")
  `LSE_ASSERT_NOW(a_err_last, result_valid && (result.status != ST_OK), result.last,
                  "error result not last")

endmodule

bind lifo_stack_engine lse_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
